### rtl/sws_pkg.sv
// Shared types and constants for the shell word splitter.
`timescale 1ns / 1ps

package sws_pkg;

	// Most result words that one input word can cause.
	localparam int MaxResults = 5;
	localparam int CntW = $clog2(MaxResults + 1);

	// Default depth of the queue between front and back.
	localparam int QueueDepthDefault = 4;

	// Configuration port geometry.
	localparam int CfgIdxW = 2;
	localparam int CfgDataW = 8;

	// Characters with a special meaning to the splitter.
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_AMP = 8'h26;

	// Result word kinds.
	typedef enum logic [1:0] {
		KIND_BYTE = 2'd0,
		KIND_END = 2'd1,
		KIND_OK = 2'd2,
		KIND_BADQUOTE = 2'd3
	} kind_t;

	// All result words of one input word, in order.
	typedef struct packed {
		logic [CntW-1:0] cnt;
		kind_t [MaxResults-1:0] kind;
		logic [MaxResults-1:0][7:0] data;
	} bundle_t;

endpackage

### rtl/sws_front.sv
// Front end: configuration registers, splitter state and word classification.
`timescale 1ns / 1ps

module sws_front (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [sws_pkg::CfgIdxW-1:0] cfg_index,
	input logic [sws_pkg::CfgDataW-1:0] cfg_data,
	input logic push,
	input logic [7:0] in_byte,
	input logic byte_present,
	input logic text_end,
	input logic q_full,
	output logic enq_valid,
	output sws_pkg::bundle_t enq_data
);
	import sws_pkg::*;

	// Register indexes on the configuration port.
	localparam logic [CfgIdxW-1:0] REG_DELIM_LENGTH = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_DELIM_FIRST = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_DELIM_SECOND = 2'd2;
	localparam logic [CfgIdxW-1:0] REG_STRIP_QUOTING = 2'd3;

	typedef struct packed {
		logic in_quote;
		logic quote_dbl;
		logic esc;
		logic tok_open;
		logic half;
	} split_state_t;

	// Outcome of one character step: new state and up to two result words.
	typedef struct packed {
		split_state_t st;
		logic [1:0] n;
		kind_t [1:0] kind;
		logic [1:0][7:0] data;
	} step_t;

	logic [1:0] delim_length_q;
	logic [7:0] delim_first_q;
	logic [7:0] delim_second_q;
	logic strip_q;
	split_state_t state_q;

	split_state_t st_next;
	bundle_t bd;
	logic accept;

	function automatic step_t start_f(input split_state_t s);
		step_t r;
		r = '0;
		r.st = s;
		return r;
	endfunction

	function automatic step_t add_op(input step_t r_in, input kind_t k, input logic [7:0] b);
		step_t r;
		r = r_in;
		r.kind[r.n[0]] = k;
		r.data[r.n[0]] = b;
		r.n = r.n + 2'd1;
		return r;
	endfunction

	function automatic step_t add_byte(input step_t r_in, input logic [7:0] b);
		step_t r;
		r = add_op(r_in, KIND_BYTE, b);
		r.st.tok_open = 1'b1;
		return r;
	endfunction

	function automatic step_t end_f(input step_t r_in);
		step_t r;
		r = r_in;
		if (r.st.tok_open) begin
			r = add_op(r, KIND_END, 8'd0);
		end
		r.st.tok_open = 1'b0;
		return r;
	endfunction

	function automatic logic is_service(input logic [7:0] b);
		return (b == CH_SPACE) || (b == CH_BSLASH) || (b == CH_SQUOTE)
			|| (b == CH_DQUOTE) || (b == CH_AMP);
	endfunction

	// A byte that is not a delimiter: quoting, escapes and plain text.
	function automatic step_t ordinary_f(input split_state_t s, input logic strip,
		input logic [7:0] b);
		step_t r;
		logic [7:0] qch;
		r = start_f(s);
		qch = s.quote_dbl ? CH_DQUOTE : CH_SQUOTE;
		if (!s.esc && (b == CH_BSLASH)) begin
			r.st.esc = 1'b1;
			if (!strip) begin
				r = add_byte(r, b);
			end
		end else if (s.esc) begin
			if ((!s.in_quote && !is_service(b))
				|| (s.in_quote && (b != CH_BSLASH) && (b != qch))) begin
				r = add_byte(r, CH_BSLASH);
			end
			r = add_byte(r, b);
			r.st.esc = 1'b0;
		end else if (s.in_quote && (b == qch)) begin
			if (!strip) begin
				r = add_byte(r, b);
			end
			r.st.in_quote = 1'b0;
		end else if (!s.in_quote && ((b == CH_DQUOTE) || (b == CH_SQUOTE))) begin
			if (!strip) begin
				r = add_byte(r, b);
			end
			r.st.in_quote = 1'b1;
			r.st.quote_dbl = (b == CH_DQUOTE);
		end else begin
			r = add_byte(r, b);
		end
		return r;
	endfunction

	// A byte that may open or be a delimiter.
	function automatic step_t take_f(input split_state_t s, input logic strip,
		input logic [1:0] dlen, input logic [7:0] dfirst, input logic [7:0] b);
		step_t r;
		r = start_f(s);
		if (!s.esc && !s.in_quote && (b == dfirst)) begin
			if (dlen[1]) begin
				r.st.half = 1'b1;
			end else begin
				r = end_f(r);
			end
		end else begin
			r = ordinary_f(s, strip, b);
		end
		return r;
	endfunction

	function automatic bundle_t append_f(input bundle_t bd_in, input step_t r);
		bundle_t b;
		b = bd_in;
		for (int i = 0; i < 2; i++) begin
			if ((2'(i) < r.n) && (b.cnt < CntW'(MaxResults))) begin
				b.kind[b.cnt] = r.kind[i];
				b.data[b.cnt] = r.data[i];
				b.cnt = b.cnt + CntW'(1);
			end
		end
		return b;
	endfunction

	// Work out every result word of the incoming word and the next state.
	always_comb begin
		split_state_t st;
		step_t r;
		st = state_q;
		r = '0;
		bd = '0;
		if (byte_present) begin
			if (st.half) begin
				st.half = 1'b0;
				if (in_byte == delim_second_q) begin
					r = end_f(start_f(st));
					st = r.st;
					bd = append_f(bd, r);
				end else begin
					r = ordinary_f(st, strip_q, delim_first_q);
					st = r.st;
					bd = append_f(bd, r);
					r = take_f(st, strip_q, delim_length_q, delim_first_q, in_byte);
					st = r.st;
					bd = append_f(bd, r);
				end
			end else begin
				r = take_f(st, strip_q, delim_length_q, delim_first_q, in_byte);
				st = r.st;
				bd = append_f(bd, r);
			end
		end
		if (text_end) begin
			if (st.half) begin
				st.half = 1'b0;
				r = ordinary_f(st, strip_q, delim_first_q);
				st = r.st;
				bd = append_f(bd, r);
			end
			r = end_f(start_f(st));
			st = r.st;
			bd = append_f(bd, r);
			r = add_op(start_f(st), st.in_quote ? KIND_BADQUOTE : KIND_OK, 8'd0);
			bd = append_f(bd, r);
			st = '0;
		end
		st_next = st;
	end

	assign accept = push && !q_full;
	assign enq_valid = accept && (bd.cnt != '0);
	assign enq_data = bd;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delim_length_q <= 2'd1;
			delim_first_q <= CH_SPACE;
			delim_second_q <= CH_AMP;
			strip_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DELIM_LENGTH: delim_length_q <= cfg_data[1:0];
				REG_DELIM_FIRST: delim_first_q <= cfg_data[7:0];
				REG_DELIM_SECOND: delim_second_q <= cfg_data[7:0];
				REG_STRIP_QUOTING: strip_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Splitter state advances on every accepted word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (accept) begin
			state_q <= st_next;
		end
	end

endmodule

### rtl/sws_queue.sv
// Short queue of result bundles between front and back.
`timescale 1ns / 1ps

module sws_queue #(
	parameter int QueueDepth = sws_pkg::QueueDepthDefault
) (
	input logic clk,
	input logic arst_n,
	input logic wr_en,
	input sws_pkg::bundle_t wr_data,
	input logic rd_en,
	output sws_pkg::bundle_t rd_data,
	output logic full,
	output logic empty
);
	import sws_pkg::*;

	localparam int AW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
	localparam int CW = $clog2(QueueDepth + 1);

	bundle_t mem_q [QueueDepth];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic do_wr;
	logic do_rd;

	assign full = (count_q == CW'(QueueDepth));
	assign empty = (count_q == '0);
	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	// Storage.
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == AW'(QueueDepth - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == AW'(QueueDepth - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

### rtl/sws_back.sv
// Back end: hands out the words of the head bundle one per pop.
`timescale 1ns / 1ps

module sws_back (
	input logic clk,
	input logic arst_n,
	input sws_pkg::bundle_t head,
	input logic q_empty,
	output logic q_pop,
	input logic pop,
	output logic empty,
	output logic [1:0] out_kind,
	output logic [7:0] out_byte,
	output logic run_last
);
	import sws_pkg::*;

	logic [CntW-1:0] idx_q;
	logic take;

	assign empty = q_empty;
	assign out_kind = head.kind[idx_q];
	assign out_byte = head.data[idx_q];
	assign run_last = (idx_q == (head.cnt - CntW'(1)));
	assign take = pop && !q_empty;
	assign q_pop = take && run_last;

	// Position inside the head bundle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (take) begin
			idx_q <= run_last ? '0 : idx_q + CntW'(1);
		end
	end

endmodule

### rtl/shell_word_splitter.sv
// Top level of the shell word splitter.
// An accepted word's result bundle is registered in the queue, read from its head.
// Throughput: one input word per cycle while full is low; results leave one word
// per cycle while pop is asserted and empty is low.
// The bundle queue (QueueDepth entries) lets input continue while results wait.
// Reset: arst_n clears splitter, queue and back-end state, restores register defaults.
`timescale 1ns / 1ps

module shell_word_splitter #(
	parameter int QueueDepth = sws_pkg::QueueDepthDefault
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [sws_pkg::CfgIdxW-1:0] cfg_index,
	input logic [sws_pkg::CfgDataW-1:0] cfg_data,
	input logic push,
	output logic full,
	input logic [7:0] in_byte,
	input logic byte_present,
	input logic text_end,
	output logic empty,
	input logic pop,
	output logic [1:0] out_kind,
	output logic [7:0] out_byte,
	output logic run_last
);
	import sws_pkg::*;

	logic enq_valid;
	bundle_t enq_data;
	bundle_t head;
	logic q_pop;
	logic q_empty;

	sws_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.push(push),
		.in_byte(in_byte),
		.byte_present(byte_present),
		.text_end(text_end),
		.q_full(full),
		.enq_valid(enq_valid),
		.enq_data(enq_data)
	);

	sws_queue #(
		.QueueDepth(QueueDepth)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(enq_valid),
		.wr_data(enq_data),
		.rd_en(q_pop),
		.rd_data(head),
		.full(full),
		.empty(q_empty)
	);

	sws_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.q_empty(q_empty),
		.q_pop(q_pop),
		.pop(pop),
		.empty(empty),
		.out_kind(out_kind),
		.out_byte(out_byte),
		.run_last(run_last)
	);

endmodule

### rtl/sws_checker.sv
// Port-level checks for the shell word splitter, bound to the top level.
`timescale 1ns / 1ps

module sws_checker (
	input logic clk,
	input logic arst_n,
	input logic push,
	input logic full,
	input logic pop,
	input logic empty,
	input logic [1:0] out_kind,
	input logic [7:0] out_byte,
	input logic run_last
);
	import sws_pkg::*;

	// A waiting word that is not popped stays in place.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(out_kind) && $stable(out_byte)
			&& $stable(run_last)))
		else $error("result word changed while stalled");

	// Only token bytes carry a byte value.
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (out_kind != KIND_BYTE)) |-> (out_byte == 8'd0))
		else $error("non-byte result carries a byte value");

	// A status word always closes the results of its input word.
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && ((out_kind == KIND_OK) || (out_kind == KIND_BADQUOTE))) |-> run_last)
		else $error("status word not last of its run");

	// Results never appear without an accepted input word.
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		($past(empty) && !$past(push && !full)) |-> empty)
		else $error("result appeared without input");

endmodule

bind shell_word_splitter sws_checker u_sws_checker (.*);
